>>> hdl/pcc_pkg.sv
package pcc_pkg;

	// Default size of the vertex ring.
	localparam int MAX_VERTICES_DEF = 64;

	// Width of the configuration write port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_Z      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRISM_HEIGHT = 2'd2;

	// Item kinds.
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// One command item.
	typedef struct packed {
		logic               kind;
		logic [5:0]         vertex_index;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
	} item_t;

	// One result item.
	typedef struct packed {
		logic inside_res;
		logic height_ok;
	} result_t;

	// One polygon vertex as held by a ring cell.
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} vertex_t;

	// Edge handed to the crossing unit: edge from vertex i to vertex j.
	typedef struct packed {
		logic               valid;
		logic signed [31:0] xi;
		logic signed [31:0] yi;
		logic signed [31:0] xj;
		logic signed [31:0] yj;
	} edge_req_t;

	// Status of the crossing unit.
	typedef struct packed {
		logic idle;
		logic parity;
	} edge_stat_t;

	// Sign extension of a coordinate to hold a difference.
	function automatic logic [32:0] sext33(logic [31:0] v);
		return {v[31], v};
	endfunction

	// Magnitude of a 33-bit two's complement difference of two coordinates.
	function automatic logic [31:0] mag32(logic [32:0] v);
		logic [32:0] m;
		m = v[32] ? (~v + 33'd1) : v;
		return m[31:0];
	endfunction

endpackage

>>> hdl/pcc_cell.sv
// One cell of the vertex ring: holds a vertex, takes a load from the
// command port or the vertex of its neighbor when the ring rotates.
module pcc_cell (
	input  logic             clk,
	input  logic             shift_en,
	input  logic             load_en,
	input  pcc_pkg::vertex_t load_vtx,
	input  pcc_pkg::vertex_t next_vtx,
	output pcc_pkg::vertex_t vtx
);

	pcc_pkg::vertex_t vtx_q;

	// Loads only happen while the ring is at rest, so the two never meet.
	always_ff @(posedge clk) begin
		if (load_en) begin
			vtx_q <= load_vtx;
		end else if (shift_en) begin
			vtx_q <= next_vtx;
		end
	end

	assign vtx = vtx_q;

endmodule

>>> hdl/pcc_edge_unit.sv
// Crossing test for one edge per cycle, three register stages deep.
// Stage 1 forms the differences, stage 2 their magnitudes, stage 3 the two
// products; the exact comparison then toggles the parity register.
module pcc_edge_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clear,
	input  pcc_pkg::edge_req_t  req,
	input  logic signed [31:0]  px,
	input  logic signed [31:0]  py,
	output pcc_pkg::edge_stat_t stat
);

	logic        valid_s1, valid_s2, valid_s3;
	logic        cross_s1, cross_s2, cross_s3;
	logic [32:0] a_s1, dy_s1, b_s1, c_s1;
	logic [31:0] am_s2, dym_s2, bm_s2, cm_s2;
	logic        aneg_s2, dyneg_s2, bcneg_s2;
	logic        aneg_s3, dyneg_s3, bcneg_s3;
	logic [63:0] lm_s3, rm_s3;
	logic        parity_q;
	logic        ln, rn, less;

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 1: the edge straddles the ray's y, and the four differences.
	always_ff @(posedge clk) begin
		cross_s1 <= (req.yi > py) != (req.yj > py);
		a_s1     <= pcc_pkg::sext33(px) - pcc_pkg::sext33(req.xi);
		dy_s1    <= pcc_pkg::sext33(req.yj) - pcc_pkg::sext33(req.yi);
		b_s1     <= pcc_pkg::sext33(req.xj) - pcc_pkg::sext33(req.xi);
		c_s1     <= pcc_pkg::sext33(py) - pcc_pkg::sext33(req.yi);
	end

	// Stage 2: sign and magnitude of each difference.
	always_ff @(posedge clk) begin
		cross_s2 <= cross_s1;
		am_s2    <= pcc_pkg::mag32(a_s1);
		dym_s2   <= pcc_pkg::mag32(dy_s1);
		bm_s2    <= pcc_pkg::mag32(b_s1);
		cm_s2    <= pcc_pkg::mag32(c_s1);
		aneg_s2  <= a_s1[32];
		dyneg_s2 <= dy_s1[32];
		bcneg_s2 <= b_s1[32] ^ c_s1[32];
	end

	// Stage 3: |px - xi| * |dy| against |xj - xi| * |py - yi|.
	always_ff @(posedge clk) begin
		cross_s3 <= cross_s2;
		lm_s3    <= am_s2 * dym_s2;
		rm_s3    <= bm_s2 * cm_s2;
		aneg_s3  <= aneg_s2;
		dyneg_s3 <= dyneg_s2;
		bcneg_s3 <= bcneg_s2;
	end

	// Signed comparison of the two products; the right side flips with the
	// direction of the edge, a zero product carries no sign.
	always_comb begin
		ln = (lm_s3 != 64'd0) && aneg_s3;
		rn = (rm_s3 != 64'd0) && (bcneg_s3 ^ dyneg_s3);
		if (ln != rn) begin
			less = ln;
		end else if (!ln) begin
			less = lm_s3 < rm_s3;
		end else begin
			less = lm_s3 > rm_s3;
		end
	end

	// Crossing parity of the query in progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
		end else if (clear) begin
			parity_q <= 1'b0;
		end else if (valid_s3 && cross_s3 && less) begin
			parity_q <= !parity_q;
		end
	end

	assign stat.idle   = !(valid_s1 || valid_s2 || valid_s3);
	assign stat.parity = parity_q;

endmodule

>>> hdl/prism_point_containment_core.sv
// Point in prism test: a polygon in the x-y plane, extruded from floor_z
// upward by prism_height, checked by the crossing-number rule.
// Commands enter on cmd, taken at a clock edge where start is high and busy
// is low. A load (kind 0) writes one vertex into the vertex ring in that
// cycle and gives no result; busy stays low, so loads can follow back to
// back. A query (kind 1) gives one result on result, marked by result_valid
// for a single cycle; the receiver cannot stall and must take it then.
// A query whose z lies outside the prism gives its result in the next cycle
// and keeps busy low. Otherwise the ring of MAX_VERTICES cells makes one full
// turn, feeding one edge per cycle into a three-stage crossing unit; the
// result comes once the last edges have drained, and busy is high until the
// result cycle. The ring's turn, not vertex_count, sets the walk's length.
// Registers are written through cfg_we / cfg_index / cfg_data at any edge
// where cfg_we is high. The user must write them only while no query is in
// progress; the block itself does not enforce this.
// Reset clears the registers and the control state; the vertex ring holds
// no defined value until its slots are loaded.
module prism_point_containment_core #(
	parameter int MAX_VERTICES = pcc_pkg::MAX_VERTICES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  pcc_pkg::item_t                   cmd,
	input  logic                             cfg_we,
	input  logic [pcc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pcc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                             result_valid,
	output pcc_pkg::result_t                 result
);

	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int NW = (CW > 7) ? CW : 7;
	localparam int LW = ($clog2(MAX_VERTICES) > 6) ? $clog2(MAX_VERTICES) : 6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       step_q;
	logic                result_valid_q;
	pcc_pkg::result_t    result_q;
	logic [6:0]          vcount_q;
	logic signed [31:0]  floor_q;
	logic [30:0]         height_q;
	logic signed [31:0]  px_q, py_q;
	pcc_pkg::vertex_t    first_q, prev_q;

	logic                accept, query, hok, clear;
	logic [NW-1:0]       vc_ext;
	logic [CW-1:0]       n_vtx;
	logic signed [33:0]  pz_e, fz_e, top_e;
	logic                walk, last_step, mid_edge, close_edge, shift_en;
	pcc_pkg::vertex_t    load_vtx;
	pcc_pkg::vertex_t    ring [MAX_VERTICES];
	pcc_pkg::edge_req_t  edge_req;
	pcc_pkg::edge_stat_t edge_stat;

	assign busy   = state_q != ST_IDLE;
	assign accept = start && !busy;
	assign query  = accept && (cmd.kind == pcc_pkg::KIND_QUERY);

	// Configuration registers; an index beyond the list writes nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
			floor_q  <= '0;
			height_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pcc_pkg::REG_VERTEX_COUNT: vcount_q <= cfg_data[6:0];
				pcc_pkg::REG_FLOOR_Z:      floor_q  <= cfg_data[31:0];
				pcc_pkg::REG_PRISM_HEIGHT: height_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Number of edges to walk, held to the size of the ring.
	assign vc_ext = NW'(vcount_q);
	assign n_vtx  = (vc_ext > NW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vc_ext);

	// Height window check on the incoming query.
	assign pz_e  = {{2{cmd.coord_z[31]}}, cmd.coord_z};
	assign fz_e  = {{2{floor_q[31]}}, floor_q};
	assign top_e = fz_e + $signed({3'b000, height_q});
	assign hok   = !(pz_e < fz_e) && !(pz_e > top_e);
	assign clear = query && hok;

	// Vertex ring: cell 0 is the head, every cell takes its upper neighbor.
	assign load_vtx.x = cmd.coord_x;
	assign load_vtx.y = cmd.coord_y;

	for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_ring
		logic load_en;
		assign load_en = accept && (cmd.kind == pcc_pkg::KIND_LOAD) &&
			(LW'(cmd.vertex_index) == LW'(k));
		pcc_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.load_en  (load_en),
			.load_vtx (load_vtx),
			.next_vtx (ring[(k + 1) % MAX_VERTICES]),
			.vtx      (ring[k])
		);
	end

	// Edge issue during the turn: at step k the head shows vertex k. Edges
	// (k, k-1) go out for k in 1 .. n-1, the closing edge (0, n-1) at step n.
	assign walk       = state_q == ST_WALK;
	assign last_step  = step_q == CW'(MAX_VERTICES);
	assign shift_en   = walk && !last_step;
	assign mid_edge   = (step_q != '0) && (step_q < n_vtx);
	assign close_edge = (step_q == n_vtx) && (n_vtx != '0);

	assign edge_req.valid = walk && (mid_edge || close_edge);
	assign edge_req.xi    = close_edge ? first_q.x : ring[0].x;
	assign edge_req.yi    = close_edge ? first_q.y : ring[0].y;
	assign edge_req.xj    = prev_q.x;
	assign edge_req.yj    = prev_q.y;

	pcc_edge_unit u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (clear),
		.req    (edge_req),
		.px     (px_q),
		.py     (py_q),
		.stat   (edge_stat)
	);

	// Query point, first vertex and the vertex one step behind the head.
	always_ff @(posedge clk) begin
		if (query) begin
			px_q <= cmd.coord_x;
			py_q <= cmd.coord_y;
		end
		if (walk) begin
			prev_q <= ring[0];
			if (step_q == '0) begin
				first_q <= ring[0];
			end
		end
	end

	// Sequencer with the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			step_q         <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (query) begin
						if (hok) begin
							state_q <= ST_WALK;
							step_q  <= '0;
						end else begin
							result_valid_q      <= 1'b1;
							result_q.inside_res <= 1'b0;
							result_q.height_ok  <= 1'b0;
						end
					end
				end
				ST_WALK: begin
					if (last_step) begin
						state_q <= ST_DRAIN;
					end else begin
						step_q <= step_q + CW'(1);
					end
				end
				ST_DRAIN: begin
					if (edge_stat.idle) begin
						state_q             <= ST_IDLE;
						result_valid_q      <= 1'b1;
						result_q.inside_res <= edge_stat.parity;
						result_q.height_ok  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// The end of a walk always hands out a result.
	a_fell_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid)
		else $error("query finished without a result transfer");

	// A point inside the polygon must also lie within the height window.
	a_inside_height: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.inside_res |-> result.height_ok)
		else $error("inside reported with height out of range");

	// A walked result is only taken once the crossing unit has drained.
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.height_ok |-> $past(edge_stat.idle))
		else $error("result taken while edges were still in flight");

	// The step counter never runs past one full turn of the ring.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> step_q <= CW'(MAX_VERTICES))
		else $error("walk step beyond the ring size");

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int NVERT = pcc_pkg::MAX_VERTICES_DEF;

	// Cycles to let pass after the last result, covering a full ring turn.
	localparam int SETTLE_CYCLES = NVERT + 16;
	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int REPORT_MAX = 10;

	// The port has one index beyond the register list; writing it does nothing.
	localparam logic [pcc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;
	localparam logic [30:0] HEIGHT_MAX = 31'h7fff_ffff;
	localparam longint ONE = 65536;

	// Half sizes of the box that polygons and queries are drawn from.
	localparam longint BOX_TINY = 8;
	localparam longint BOX_MID = 1 << 20;
	localparam longint BOX_FULL = longint'(1) << 31;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	pcc_pkg::item_t cmd = '0;
	logic cfg_we = 1'b0;
	logic [pcc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pcc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic result_valid;
	pcc_pkg::result_t result;

	prism_point_containment_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the block's registers and vertex ring.
	logic signed [31:0] poly_x [NVERT];
	logic signed [31:0] poly_y [NVERT];
	logic [6:0] shadow_count = '0;
	logic signed [31:0] shadow_floor = '0;
	logic [30:0] shadow_height = '0;

	pcc_pkg::result_t pending_verdicts [$];
	pcc_pkg::result_t oldest_verdict;
	int mismatch_count = 0;
	int burst_left = 0;
	int cycle_count = 0;

	task automatic note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("[%0t] ERROR: %s", $time, msg);
	endtask

	// Exact crossing-number verdict for one query against the shadow state.
	function automatic pcc_pkg::result_t predict_containment(input pcc_pkg::item_t q);
		pcc_pkg::result_t r;
		longint fz, top, pz;
		int n, j;
		logic parity;
		logic signed [67:0] px, py, xi, yi, xj, yj, dy, lhs, rhs;
		r = '0;
		fz = longint'(shadow_floor);
		top = fz + longint'(shadow_height);
		pz = longint'($signed(q.coord_z));
		if (pz < fz || pz > top)
			return r;
		n = (int'(shadow_count) > NVERT) ? NVERT : int'(shadow_count);
		parity = 1'b0;
		px = $signed(q.coord_x);
		py = $signed(q.coord_y);
		for (int i = 0; i < n; i++) begin
			// Each vertex pairs with its predecessor; vertex 0 closes onto the last.
			j = (i == 0) ? n - 1 : i - 1;
			xi = poly_x[i];
			yi = poly_y[i];
			xj = poly_x[j];
			yj = poly_y[j];
			if ((yi > py) != (yj > py)) begin
				// Division by dy is replaced by multiplying through by |dy|.
				dy = yj - yi;
				lhs = (px - xi) * ((dy < 0) ? -dy : dy);
				rhs = (xj - xi) * (py - yi);
				if (dy < 0)
					rhs = -rhs;
				if (lhs < rhs)
					parity = ~parity;
			end
		end
		r.inside_res = parity;
		r.height_ok = 1'b1;
		return r;
	endfunction

	// Check each result, then track register writes and accepted transfers.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid) begin
				if (pending_verdicts.size() == 0) begin
					note_failure($sformatf("unexpected result inside=%b height_ok=%b",
						result.inside_res, result.height_ok));
				end else begin
					oldest_verdict = pending_verdicts.pop_front();
					if (result.inside_res !== oldest_verdict.inside_res ||
							result.height_ok !== oldest_verdict.height_ok)
						note_failure($sformatf(
							"expected inside=%b height_ok=%b, got inside=%b height_ok=%b",
							oldest_verdict.inside_res, oldest_verdict.height_ok,
							result.inside_res, result.height_ok));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					pcc_pkg::REG_VERTEX_COUNT: shadow_count = cfg_data[6:0];
					pcc_pkg::REG_FLOOR_Z: shadow_floor = $signed(cfg_data);
					pcc_pkg::REG_PRISM_HEIGHT: shadow_height = cfg_data[30:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (cmd.kind == pcc_pkg::KIND_QUERY) begin
					pending_verdicts = {pending_verdicts, predict_containment(cmd)};
				end else if (int'(cmd.vertex_index) < NVERT) begin
					poly_x[cmd.vertex_index] = cmd.coord_x;
					poly_y[cmd.vertex_index] = cmd.coord_y;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic longint rand_between(input longint lo, input longint hi);
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return lo + longint'(r % (64'(hi - lo) + 64'd1));
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v < longint'(COORD_MIN))
			return COORD_MIN;
		if (v > longint'(COORD_MAX))
			return COORD_MAX;
		return v[31:0];
	endfunction

	// A z near or on the prism bounds, or anywhere at all now and then.
	function automatic logic signed [31:0] pick_z(input longint fz, input longint top);
		case ($urandom_range(0, 11))
			0: return clamp32(fz);
			1: return clamp32(top);
			2: return clamp32(fz - 1);
			3: return clamp32(top + 1);
			4, 5: return $urandom();
			default: return clamp32(rand_between(fz,
				(top > longint'(COORD_MAX)) ? longint'(COORD_MAX) : top));
		endcase
	endfunction

	function automatic logic signed [31:0] pick_coord(input longint box, input bit roomy);
		longint reach;
		if (box >= BOX_FULL || $urandom_range(0, 19) == 0)
			return $urandom();
		reach = roomy ? box + box / 4 + 2 : box;
		return clamp32(rand_between(-reach, reach));
	endfunction

	// Offer one item and hold it until the transfer, then maybe pause.
	task automatic send_item(input pcc_pkg::item_t it);
		int gap;
		start <= 1'b1;
		cmd <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) :
				$urandom_range(0, 12);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 90) :
				$urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end
	endtask

	task automatic send_load(input int slot, input logic signed [31:0] x,
			input logic signed [31:0] y);
		pcc_pkg::item_t it;
		it.kind = pcc_pkg::KIND_LOAD;
		it.vertex_index = 6'(slot);
		it.coord_x = x;
		it.coord_y = y;
		it.coord_z = $urandom();
		send_item(it);
	endtask

	task automatic send_query(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] z);
		pcc_pkg::item_t it;
		it.kind = pcc_pkg::KIND_QUERY;
		it.vertex_index = 6'($urandom());
		it.coord_x = x;
		it.coord_y = y;
		it.coord_z = z;
		send_item(it);
	endtask

	// Wait for every outstanding result, then for one more ring turn.
	task automatic settle_block();
		start <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [pcc_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_prism(input int count, input logic signed [31:0] floor_val,
			input logic [30:0] height);
		write_reg(pcc_pkg::REG_VERTEX_COUNT, 32'(count));
		write_reg(pcc_pkg::REG_FLOOR_Z, floor_val);
		write_reg(pcc_pkg::REG_PRISM_HEIGHT, {1'b0, height});
	endtask

	// Out of reset: no vertices and a flat prism at z = 0.
	task automatic test_reset_state();
		send_query(32'sd0, 32'sd0, 32'sd0);
		send_query(COORD_MAX, COORD_MIN, 32'sd1);
		settle_block();
	endtask

	// A 10 by 10 square, probed inside, outside, on its edges and at the z bounds.
	task automatic test_square();
		set_prism(4, clamp32(-5 * ONE), 31'(10 * ONE));
		send_load(0, 32'sd0, 32'sd0);
		send_load(1, clamp32(10 * ONE), 32'sd0);
		send_load(2, clamp32(10 * ONE), clamp32(10 * ONE));
		send_load(3, 32'sd0, clamp32(10 * ONE));
		send_load(NVERT - 1, COORD_MIN, COORD_MAX);
		send_query(clamp32(5 * ONE), clamp32(5 * ONE), 32'sd0);
		send_query(clamp32(15 * ONE), clamp32(5 * ONE), 32'sd0);
		send_query(32'sd0, clamp32(5 * ONE), 32'sd0);
		send_query(clamp32(10 * ONE), clamp32(5 * ONE), 32'sd0);
		send_query(32'sd0, 32'sd0, 32'sd0);
		send_query(clamp32(5 * ONE), clamp32(10 * ONE), 32'sd0);
		send_query(clamp32(5 * ONE), clamp32(5 * ONE), clamp32(-5 * ONE));
		send_query(clamp32(5 * ONE), clamp32(5 * ONE), clamp32(5 * ONE));
		send_query(clamp32(5 * ONE), clamp32(5 * ONE), clamp32(-5 * ONE - 1));
		send_query(clamp32(5 * ONE), clamp32(5 * ONE), clamp32(5 * ONE + 1));
		send_query(COORD_MIN, clamp32(5 * ONE), 32'sd0);
		send_query(COORD_MAX, COORD_MAX, 32'sd0);
		settle_block();
		// The first three corners alone make a triangle.
		write_reg(pcc_pkg::REG_VERTEX_COUNT, 32'd3);
		send_query(clamp32(8 * ONE), clamp32(2 * ONE), 32'sd0);
		send_query(clamp32(2 * ONE), clamp32(8 * ONE), 32'sd0);
		settle_block();
		// With no vertices nothing is inside even at a good height.
		write_reg(pcc_pkg::REG_VERTEX_COUNT, 32'd0);
		send_query(clamp32(5 * ONE), clamp32(5 * ONE), 32'sd0);
		settle_block();
		// A write beyond the register list must leave the square untouched.
		write_reg(pcc_pkg::REG_VERTEX_COUNT, 32'd4);
		write_reg(REG_UNUSED, 32'hffff_ffff);
		send_query(clamp32(5 * ONE), clamp32(5 * ONE), 32'sd0);
		settle_block();
	endtask

	// Every slot gets a vertex, so any vertex count is safe from here on.
	task automatic test_fill_ring();
		for (int s = 0; s < NVERT; s++)
			send_load(s, $urandom(), $urandom());
		settle_block();
	endtask

	// Phases of fresh polygons and random queries under varied prism settings.
	task automatic test_random_phases();
		int count, used;
		logic signed [31:0] floor_val;
		logic [30:0] height;
		longint box, fz, top;
		for (int p = 0; p < 8; p++) begin
			floor_val = $urandom();
			height = 31'($urandom());
			count = $urandom_range(3, NVERT);
			box = (p % 3 == 0) ? BOX_TINY : (p % 3 == 1) ? BOX_MID : BOX_FULL;
			case (p)
				0: begin
					count = NVERT;
					floor_val = COORD_MIN;
					height = HEIGHT_MAX;
				end
				1: count = 127;
				2: begin
					count = 3;
					floor_val = 32'sd0;
					height = '0;
				end
				3: count = 0;
				4: begin
					count = NVERT + 1;
					floor_val = COORD_MAX;
					height = HEIGHT_MAX;
				end
				default: ;
			endcase
			set_prism(count, floor_val, height);
			fz = longint'(floor_val);
			top = fz + longint'(height);
			used = (count > NVERT) ? NVERT : count;
			for (int s = 0; s < used; s++)
				send_load(s, pick_coord(box, 1'b0), pick_coord(box, 1'b0));
			for (int k = 0; k < 200; k++) begin
				if ($urandom_range(0, 6) == 0)
					send_load($urandom_range(0, NVERT - 1), pick_coord(box, 1'b0),
						pick_coord(box, 1'b0));
				else
					send_query(pick_coord(box, 1'b1), pick_coord(box, 1'b1),
						pick_z(fz, top));
			end
			settle_block();
		end
	endtask

	initial begin
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_square();
		test_fill_ring();
		test_random_phases();
		if (pending_verdicts.size() != 0)
			note_failure($sformatf("%0d results never arrived", pending_verdicts.size()));
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
